### rtl/lzwc_pkg.sv
// Package for the LZW byte stream compressor.
// Holds transfer structs, engine state type and shared constants; no dependencies.
package lzwc_pkg;

  localparam int ROOT_CODES       = 256;
  localparam int START_WIDTH      = 8;
  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int QUEUE_DEPTH      = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        end_of_stream;
    logic [31:0] total_bytes;
  } out_item_t;

  // item as held between front and back, tagged with its stream position
  typedef struct packed {
    in_item_t item;
    logic     first;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_MISS,
    ST_ADD,
    ST_FINAL
  } eng_state_t;

endpackage

### rtl/lzwc_front.sv
// Front end: accepts input transfers, tags the first byte of each stream,
// and queues items for the dictionary engine. Depends on lzwc_pkg.
module lzwc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  lzwc_pkg::in_item_t item,
  output logic               q_valid,
  output lzwc_pkg::q_item_t  q_item,
  input  logic               q_take
);

  localparam int PW = $clog2(lzwc_pkg::QUEUE_DEPTH);

  lzwc_pkg::q_item_t mem [lzwc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   cnt;
  logic          in_stream;
  logic          wr, rd;

  assign full    = (cnt == (PW+1)'(lzwc_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt != '0);
  assign q_item  = mem[rp];
  assign wr      = push && !full;
  assign rd      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= '{item: item, first: !in_stream};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      cnt       <= '0;
      in_stream <= 1'b0;
    end else begin
      if (wr) begin
        wp        <= wp + PW'(1);
        in_stream <= !item.last_byte;
      end
      if (rd) begin
        rp <= rp + PW'(1);
      end
      cnt <= cnt + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule

### rtl/lzwc_engine.sv
// Back end: LZW dictionary engine. Child/sibling trie in block memories,
// one probe per cycle; hands codes to the packer. Depends on lzwc_pkg.
module lzwc_engine #(
  parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF,
  parameter int CW           = $clog2(DICT_ENTRIES),
  parameter int WW           = $clog2(CW + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lzwc_pkg::q_item_t q_item,
  output logic              q_take,
  output logic              code_valid,
  output logic [CW-1:0]     code,
  output logic [WW-1:0]     code_width,
  output logic              code_flush,
  input  logic              code_ready
);

  localparam int NW = CW + 1;

  logic [CW-1:0] head_mem [DICT_ENTRIES];
  logic [CW-1:0] sib_mem  [DICT_ENTRIES];
  logic [7:0]    ext_mem  [DICT_ENTRIES];
  logic [255:0]  root_vld;

  lzwc_pkg::eng_state_t st, st_next;
  logic [CW-1:0] prefix, prefix_next;
  logic [CW-1:0] cand, cand_next;
  logic [CW-1:0] hsav, hsav_next;
  logic [NW-1:0] next_code, next_code_next;
  logic [WW-1:0] width, width_next;
  logic [7:0]    cur_byte, cur_byte_next;
  logic          cur_last, cur_last_next;

  logic          head_re, head_we, node_re, node_we, root_set, root_clr;
  logic [CW-1:0] head_ra, head_wa, head_wd, node_ra;
  logic [CW-1:0] head_q, sib_q, c_head;
  logic [7:0]    ext_q;
  logic          is_root;

  assign is_root    = (prefix[CW-1:8] == '0);
  assign c_head     = (is_root && !root_vld[prefix[7:0]]) ? '0 : head_q;
  assign code       = prefix;
  assign code_width = width;
  assign code_valid = (st == lzwc_pkg::ST_MISS) || (st == lzwc_pkg::ST_FINAL);
  assign code_flush = (st == lzwc_pkg::ST_FINAL);

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_q <= head_mem[head_ra];
    end
    if (node_we) begin
      sib_mem[next_code[CW-1:0]] <= hsav;
      ext_mem[next_code[CW-1:0]] <= cur_byte;
    end
    if (node_re) begin
      sib_q <= sib_mem[node_ra];
      ext_q <= ext_mem[node_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= lzwc_pkg::ST_IDLE;
      prefix    <= '0;
      next_code <= NW'(lzwc_pkg::ROOT_CODES);
      width     <= WW'(lzwc_pkg::START_WIDTH);
      root_vld  <= '0;
    end else begin
      st        <= st_next;
      prefix    <= prefix_next;
      next_code <= next_code_next;
      width     <= width_next;
      if (root_clr) begin
        root_vld <= '0;
      end else if (root_set) begin
        root_vld[prefix[7:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand     <= cand_next;
    hsav     <= hsav_next;
    cur_byte <= cur_byte_next;
    cur_last <= cur_last_next;
  end

  always_comb begin
    st_next        = st;
    prefix_next    = prefix;
    cand_next      = cand;
    hsav_next      = hsav;
    next_code_next = next_code;
    width_next     = width;
    cur_byte_next  = cur_byte;
    cur_last_next  = cur_last;
    q_take         = 1'b0;
    head_re        = 1'b0;
    head_ra        = prefix;
    head_we        = 1'b0;
    head_wa        = prefix;
    head_wd        = next_code[CW-1:0];
    node_re        = 1'b0;
    node_ra        = cand;
    node_we        = 1'b0;
    root_set       = 1'b0;
    root_clr       = 1'b0;
    unique case (st)
      lzwc_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_take        = 1'b1;
          cur_byte_next = q_item.item.data_byte;
          cur_last_next = q_item.item.last_byte;
          if (q_item.first) begin
            prefix_next = CW'(q_item.item.data_byte);
            st_next     = q_item.item.last_byte ? lzwc_pkg::ST_FINAL : lzwc_pkg::ST_IDLE;
          end else begin
            head_re = 1'b1;
            st_next = lzwc_pkg::ST_HEAD;
          end
        end
      end
      lzwc_pkg::ST_HEAD: begin
        hsav_next = c_head;
        if (c_head == '0) begin
          st_next = lzwc_pkg::ST_MISS;
        end else begin
          node_re   = 1'b1;
          node_ra   = c_head;
          cand_next = c_head;
          st_next   = lzwc_pkg::ST_WALK;
        end
      end
      lzwc_pkg::ST_WALK: begin
        if (ext_q == cur_byte) begin
          prefix_next = cand;
          st_next     = cur_last ? lzwc_pkg::ST_FINAL : lzwc_pkg::ST_IDLE;
        end else if (sib_q == '0) begin
          st_next = lzwc_pkg::ST_MISS;
        end else begin
          node_re   = 1'b1;
          node_ra   = sib_q;
          cand_next = sib_q;
        end
      end
      lzwc_pkg::ST_MISS: begin
        if (code_ready) begin
          if (next_code < NW'(DICT_ENTRIES)) begin
            if (next_code >= (NW'(1) << width)) begin
              width_next = width + WW'(1);
            end
            node_we  = 1'b1;
            head_we  = 1'b1;
            root_set = is_root;
            st_next  = lzwc_pkg::ST_ADD;
          end else begin
            prefix_next = CW'(cur_byte);
            st_next     = cur_last ? lzwc_pkg::ST_FINAL : lzwc_pkg::ST_IDLE;
          end
        end
      end
      lzwc_pkg::ST_ADD: begin
        head_we        = 1'b1;
        head_wa        = next_code[CW-1:0];
        head_wd        = '0;
        next_code_next = next_code + NW'(1);
        prefix_next    = CW'(cur_byte);
        st_next        = cur_last ? lzwc_pkg::ST_FINAL : lzwc_pkg::ST_IDLE;
      end
      lzwc_pkg::ST_FINAL: begin
        if (code_ready) begin
          width_next     = WW'(lzwc_pkg::START_WIDTH);
          next_code_next = NW'(lzwc_pkg::ROOT_CODES);
          root_clr       = 1'b1;
          st_next        = lzwc_pkg::ST_IDLE;
        end
      end
      default: st_next = lzwc_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/lzwc_packer.sv
// Bit packer: packs codes MSB first into bytes, pads the stream end, counts
// bytes, and queues results for the output side. Depends on lzwc_pkg.
module lzwc_packer #(
  parameter int CW = $clog2(lzwc_pkg::DICT_ENTRIES_DEF),
  parameter int WW = $clog2(CW + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                code_valid,
  input  logic [CW-1:0]       code,
  input  logic [WW-1:0]       code_width,
  input  logic                code_flush,
  output logic                code_ready,
  output logic                empty,
  input  logic                pop,
  output lzwc_pkg::out_item_t result
);

  localparam int AW = CW + 8;
  localparam int KW = $clog2(AW + 1);
  localparam int PW = $clog2(lzwc_pkg::QUEUE_DEPTH);

  logic [AW-1:0] acc;
  logic [KW-1:0] cnt;
  logic          flushing;
  logic [31:0]   bcount, bcount_inc;

  lzwc_pkg::out_item_t mem [lzwc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   fcnt;
  logic          ofull, wr, rd, have_byte, take;
  lzwc_pkg::out_item_t wd;
  logic [AW-1:0] sh;
  logic [7:0]    pad;

  assign ofull      = (fcnt == (PW+1)'(lzwc_pkg::QUEUE_DEPTH));
  assign empty      = (fcnt == '0);
  assign result     = mem[rp];
  assign rd         = pop && !empty;
  assign code_ready = (cnt < KW'(8)) && !flushing;
  assign take       = code_valid && code_ready;
  assign have_byte  = (cnt >= KW'(8)) || (flushing && cnt != '0);
  assign wr         = have_byte && !ofull;
  assign bcount_inc = (bcount == '1) ? bcount : bcount + 32'd1;
  assign sh         = acc >> (cnt - KW'(8));
  assign pad        = acc[7:0] << (KW'(8) - cnt);

  always_comb begin
    wd = '0;
    if (cnt >= KW'(8)) begin
      wd.out_byte      = sh[7:0];
      wd.end_of_stream = flushing && (cnt == KW'(8));
    end else begin
      wd.out_byte      = pad;
      wd.end_of_stream = 1'b1;
    end
    if (wd.end_of_stream) begin
      wd.total_bytes = bcount_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wd;
    end
    if (take) begin
      acc <= (acc << code_width) | AW'(code);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      flushing <= 1'b0;
      bcount   <= '0;
      wp       <= '0;
      rp       <= '0;
      fcnt     <= '0;
    end else begin
      if (take) begin
        cnt      <= cnt + KW'(code_width);
        flushing <= code_flush;
      end else if (wr) begin
        if (wd.end_of_stream) begin
          cnt      <= '0;
          flushing <= 1'b0;
          bcount   <= '0;
        end else begin
          cnt    <= cnt - KW'(8);
          bcount <= bcount_inc;
        end
      end
      if (wr) begin
        wp <= wp + PW'(1);
      end
      if (rd) begin
        rp <= rp + PW'(1);
      end
      fcnt <= fcnt + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule

### rtl/lzw_byte_stream_compressor_core.sv
// LZW byte stream compressor, queue-style ports on both sides. A byte that
// opens a stream only sets the prefix; any other byte reads the trie head and
// then probes one child node at a time, and on a miss emits the prefix code
// and adds a dictionary entry (no entry once the dictionary is full). A byte
// that ends a stream also sends the final code. A miss or a stream end also
// waits while the packer still holds a whole byte or is flushing; bytes are
// taken into a 4-deep queue meanwhile. The trie walk, one node memory read per
// cycle, sets the rate. Output bytes leave from a 4-deep queue at one per
// cycle. No clearing pass is needed at reset.
// Depends on lzwc_pkg, lzwc_front, lzwc_engine and lzwc_packer.
module lzw_byte_stream_compressor_core #(
  parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  lzwc_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output lzwc_pkg::out_item_t result
);

  localparam int CW = $clog2(DICT_ENTRIES);
  localparam int WW = $clog2(CW + 1);

  logic              q_valid, q_take;
  lzwc_pkg::q_item_t q_item;
  logic              code_valid, code_ready, code_flush;
  logic [CW-1:0]     code;
  logic [WW-1:0]     code_width;

  lzwc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  lzwc_engine #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .CW           (CW),
    .WW           (WW)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_take     (q_take),
    .code_valid (code_valid),
    .code       (code),
    .code_width (code_width),
    .code_flush (code_flush),
    .code_ready (code_ready)
  );

  lzwc_packer #(
    .CW (CW),
    .WW (WW)
  ) u_packer (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code       (code),
    .code_width (code_width),
    .code_flush (code_flush),
    .code_ready (code_ready),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
